// File: design/chd_pkg.sv
package chd_pkg;

  localparam int unsigned SIZE_BITS_DEF = 32;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned NIB_W    = 4;

  // final and sticky status codes
  localparam logic [STATUS_W-1:0] ST_RUN      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HDR  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_BODY = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd6;

  // input kinds carried in s_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [NIB_W-1:0]  HEX_TEN  = 4'd10;

  typedef enum logic [6:0] {
    PH_SIZE_FIRST = 7'b0000001,
    PH_SIZE_MORE  = 7'b0000010,
    PH_EXT        = 7'b0000100,
    PH_HDR_LF     = 7'b0001000,
    PH_DATA       = 7'b0010000,
    PH_BODY_CR    = 7'b0100000,
    PH_BODY_LF    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                out_valid;
    logic [BYTE_W-1:0]   out_byte;
  } result_t;

  typedef struct packed {
    logic              ok;
    logic [NIB_W-1:0]  nib;
  } hex_t;

  function automatic hex_t hex_digit(input logic [BYTE_W-1:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = '0;
    if (b >= CH_0 && b <= CH_9) begin
      h.nib = NIB_W'(b - CH_0);
    end else if (b >= CH_LO_A && b <= CH_LO_F) begin
      h.nib = NIB_W'(b - CH_LO_A) + HEX_TEN;
    end else if (b >= CH_UP_A && b <= CH_UP_F) begin
      h.nib = NIB_W'(b - CH_UP_A) + HEX_TEN;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: design/chd_step.sv
module chd_step #(
  parameter int unsigned SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
  input  logic                      opcode,
  input  logic [chd_pkg::BYTE_W-1:0] in_byte,
  input  chd_pkg::phase_t           phase,
  input  logic [SIZE_BITS-1:0]      count,
  input  logic [chd_pkg::STATUS_W-1:0] status,
  output chd_pkg::phase_t           phase_next,
  output logic [SIZE_BITS-1:0]      count_next,
  output logic [chd_pkg::STATUS_W-1:0] status_next,
  output chd_pkg::result_t          res
);
  import chd_pkg::*;

  hex_t                 hx;
  logic [SIZE_BITS-1:0] count_dec;
  logic                 top_busy;
  logic [STATUS_W-1:0]  end_status;

  assign hx        = hex_digit(in_byte);
  assign count_dec = count - SIZE_BITS'(1);
  // another digit would push the size out of the counter
  assign top_busy  = |count[SIZE_BITS-1 -: NIB_W];

  always_comb begin
    if (status != ST_RUN) begin
      end_status = status;
    end else begin
      unique case (phase)
        PH_SIZE_FIRST:          end_status = ST_BAD_SIZE;
        PH_DATA:                end_status = ST_TRUNC;
        PH_BODY_CR, PH_BODY_LF: end_status = ST_BAD_BODY;
        default:                end_status = ST_BAD_HDR;
      endcase
    end
  end

  always_comb begin
    phase_next    = phase;
    count_next    = count;
    status_next   = status;
    res.out_byte  = '0;
    res.out_valid = 1'b0;
    if (opcode == OP_END) begin
      phase_next  = PH_SIZE_FIRST;
      count_next  = '0;
      status_next = ST_RUN;
    end else if (status == ST_RUN) begin
      unique case (phase)
        PH_SIZE_FIRST: begin
          if (!hx.ok) begin
            status_next = ST_BAD_SIZE;
          end else begin
            count_next = SIZE_BITS'(hx.nib);
            phase_next = PH_SIZE_MORE;
          end
        end
        PH_SIZE_MORE: begin
          if (hx.ok) begin
            if (top_busy) begin
              status_next = ST_OVERFLOW;
            end else begin
              count_next = {count[SIZE_BITS-NIB_W-1:0], hx.nib};
            end
          end else if (in_byte == CH_CR) begin
            phase_next = PH_HDR_LF;
          end else if (in_byte == CH_LF) begin
            status_next = ST_BAD_HDR;
          end else begin
            phase_next = PH_EXT;
          end
        end
        PH_EXT: begin
          if (in_byte == CH_CR) begin
            phase_next = PH_HDR_LF;
          end else if (in_byte == CH_LF) begin
            status_next = ST_BAD_HDR;
          end
        end
        PH_HDR_LF: begin
          if (in_byte != CH_LF) begin
            status_next = ST_BAD_HDR;
          end else if (count == '0) begin
            status_next = ST_DONE;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          res.out_byte  = in_byte;
          res.out_valid = 1'b1;
          count_next    = count_dec;
          if (count_dec == '0) begin
            phase_next = PH_BODY_CR;
          end
        end
        PH_BODY_CR: begin
          if (in_byte == CH_CR) begin
            phase_next = PH_BODY_LF;
          end else begin
            status_next = ST_BAD_BODY;
          end
        end
        PH_BODY_LF: begin
          if (in_byte == CH_LF) begin
            phase_next = PH_SIZE_FIRST;
            count_next = '0;
          end else begin
            status_next = ST_BAD_BODY;
          end
        end
        default: begin
          status_next = ST_BAD_SIZE;
        end
      endcase
    end
    res.status = (opcode == OP_END) ? end_status : status_next;
  end

endmodule

// File: design/http_chunked_body_decoder_top.sv
// channel  dir  tdata                                tuser            tlast
// s_axis   in   [7:0] in_byte                        opcode (1 = end) -
// m_axis   out  [7:0] out_byte, [10:8] status        out_valid        -
//
// one byte accepted per clock while m_tready does not stall, one result per byte, via
// an input register, then a result register; the parse state is updated in the
// cycle an item leaves the input register, so consecutive bytes flow back to back
// rst is synchronous and clears the parser to the first size digit, running status
// a stalled m_tready holds the result register and backs up into s_tready
module http_chunked_body_decoder_top #(
  parameter int unsigned SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        m_tuser    // [0] out_valid
);
  import chd_pkg::*;

  logic                in_vld;
  logic                in_op;
  logic [BYTE_W-1:0]   in_data;
  logic                out_vld;
  result_t             out_res;

  phase_t              phase;
  phase_t              phase_next;
  logic [SIZE_BITS-1:0] count;
  logic [SIZE_BITS-1:0] count_next;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] status_next;
  result_t             res;

  logic                adv;
  logic                proc;

  assign adv      = !out_vld || m_tready;
  assign proc     = in_vld && adv;
  assign s_tready = !in_vld || adv;

  chd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .opcode      (in_op),
    .in_byte     (in_data),
    .phase       (phase),
    .count       (count),
    .status      (status),
    .phase_next  (phase_next),
    .count_next  (count_next),
    .status_next (status_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
      phase   <= PH_SIZE_FIRST;
      count   <= '0;
      status  <= ST_RUN;
    end else begin
      if (s_tready) begin
        in_vld <= s_tvalid;
      end
      if (adv) begin
        out_vld <= in_vld;
      end
      if (proc) begin
        phase  <= phase_next;
        count  <= count_next;
        status <= status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_data <= s_tdata;
    end
    if (proc) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {5'b0, out_res.status, out_res.out_byte};
  assign m_tuser  = out_res.out_valid;

  // payload only leaves while the parser is running
  a_payload_running: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[10:8] == ST_RUN))
    else $error("payload byte with non-running status");

  // an error or completion sticks until an end item
  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    (proc && in_op == OP_BYTE && status != ST_RUN) |=> (status == $past(status)))
    else $error("sticky status changed on a byte item");

  // the payload phase never sits with nothing left to pass
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (status == ST_RUN && phase == PH_DATA) |-> (count != '0))
    else $error("payload phase with zero count");

endmodule
